// ===== rtl/i2ctrf_pkg.sv =====
// Shared types and constants for the bus target register file.
`timescale 1ns / 1ps

package i2ctrf_pkg;

    localparam int MAP_BYTES_DEFAULT = 256;

    localparam logic [7:0] BUSY_MASK_RESET = 8'h01;
    localparam logic [7:0] STATUS_ADDR     = 8'd1;

    localparam logic [2:0] FUNC_START_WR = 3'd0;
    localparam logic [2:0] FUNC_START_RD = 3'd1;
    localparam logic [2:0] FUNC_BUS_WR   = 3'd2;
    localparam logic [2:0] FUNC_BUS_RD   = 3'd3;
    localparam logic [2:0] FUNC_STOP     = 3'd4;
    localparam logic [2:0] FUNC_LOCAL_WR = 3'd5;
    localparam logic [2:0] FUNC_LOCAL_RD = 3'd6;

    localparam logic [7:0] CTRL_ADDR_LAST_LOW = 8'd4;
    localparam logic [7:0] CTRL_ADDR_A        = 8'd8;
    localparam logic [7:0] CTRL_ADDR_B        = 8'd9;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] local_address;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       notify;
        logic [7:0] notify_pointer;
    } out_item_t;

    function automatic logic is_ctrl_addr(input logic [7:0] a);
        return (a <= CTRL_ADDR_LAST_LOW) || (a == CTRL_ADDR_A) || (a == CTRL_ADDR_B);
    endfunction

endpackage

// ===== rtl/i2c_target_register_file_unit.sv =====
// Top level of the bus target register file with auto-increment pointer.
`timescale 1ns / 1ps

// The unit accepts one transaction per clock cycle while the result side is not stalled.
// A result passes the registered read port of the byte memory and the stage-one registers,
// then the result register. The status byte at address 1 is held in its own register, and
// a valid bit per memory entry makes unwritten bytes read as zero, so no clearing pass runs
// after reset.
module i2c_target_register_file_unit #(
    parameter int MAP_BYTES = i2ctrf_pkg::MAP_BYTES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2ctrf_pkg::in_item_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2ctrf_pkg::out_item_t m_data,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data
);
    import i2ctrf_pkg::*;

    localparam int AW = $clog2(MAP_BYTES);
    localparam logic [AW-1:0] STATUS_IDX = AW'(STATUS_ADDR);

    function automatic logic [AW-1:0] map_idx(input logic [7:0] a);
        logic [8:0] v;
        v = {1'b0, a};
        for (int k = 4; k >= 0; k--) begin
            if (int'(v) >= (MAP_BYTES << k)) begin
                v = v - 9'(MAP_BYTES << k);
            end
        end
        return v[AW-1:0];
    endfunction

    logic [7:0]           mem [MAP_BYTES];
    logic [MAP_BYTES-1:0] mem_valid_reg;
    logic [7:0]           mem_rdata_reg;

    logic [7:0] busy_mask_reg;
    logic [7:0] status_reg, status_next;
    logic [7:0] ptr_reg, ptr_next;
    logic       loaded_reg, loaded_next;

    logic       p1_valid_reg;
    logic       p1_use_mem_reg, p1_use_mem_next;
    logic       p1_mem_valid_reg;
    logic [7:0] p1_byte_reg, p1_byte_next;
    logic       p1_notify_reg, p1_notify_next;
    logic [7:0] p1_ptr_reg, p1_ptr_next;

    logic            m_valid_reg;
    out_item_t       m_data_reg;
    out_item_t       p1_out;

    logic            accept;
    logic            p1_advance;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [AW-1:0]   ptr_idx, laddr_idx;

    assign p1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !p1_valid_reg || p1_advance;
    assign accept     = s_valid && s_ready;
    assign ptr_idx    = map_idx(ptr_reg);
    assign laddr_idx  = map_idx(s_data.local_address);

    always_comb begin
        ptr_next        = ptr_reg;
        loaded_next     = loaded_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_idx;
        mem_re          = 1'b0;
        mem_raddr       = ptr_idx;
        p1_use_mem_next = 1'b0;
        p1_byte_next    = 8'd0;
        p1_notify_next  = 1'b0;
        p1_ptr_next     = 8'd0;
        if (accept) begin
            unique case (s_data.func)
                FUNC_START_WR: begin
                    loaded_next = 1'b0;
                end
                FUNC_BUS_WR: begin
                    if (!loaded_reg) begin
                        ptr_next    = s_data.data;
                        loaded_next = 1'b1;
                    end else begin
                        if (ptr_idx == STATUS_IDX) begin
                            status_next = s_data.data;
                        end else begin
                            mem_we = 1'b1;
                        end
                        if (is_ctrl_addr(ptr_reg)) begin
                            status_next = status_next | busy_mask_reg;
                        end else begin
                            ptr_next = ptr_reg + 8'd1;
                        end
                    end
                end
                FUNC_BUS_RD: begin
                    if (ptr_idx == STATUS_IDX) begin
                        p1_byte_next = status_reg;
                    end else begin
                        mem_re          = 1'b1;
                        p1_use_mem_next = 1'b1;
                    end
                    ptr_next = ptr_reg + 8'd1;
                end
                FUNC_STOP: begin
                    if (status_reg != 8'd0) begin
                        p1_notify_next = 1'b1;
                        p1_ptr_next    = ptr_reg;
                    end
                end
                FUNC_LOCAL_WR: begin
                    mem_waddr = laddr_idx;
                    if (laddr_idx == STATUS_IDX) begin
                        status_next = s_data.data;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
                FUNC_LOCAL_RD: begin
                    mem_raddr = laddr_idx;
                    if (laddr_idx == STATUS_IDX) begin
                        p1_byte_next = status_reg;
                    end else begin
                        mem_re          = 1'b1;
                        p1_use_mem_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= s_data.data;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_valid_reg <= '0;
        end else if (mem_we) begin
            mem_valid_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_mask_reg <= BUSY_MASK_RESET;
            status_reg    <= 8'd0;
            ptr_reg       <= 8'd0;
            loaded_reg    <= 1'b0;
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                busy_mask_reg <= cfg_wr_data;
            end
            status_reg <= status_next;
            ptr_reg    <= ptr_next;
            loaded_reg <= loaded_next;
            if (s_ready) begin
                p1_valid_reg <= s_valid;
            end
            if (p1_advance) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_use_mem_reg   <= p1_use_mem_next;
            p1_mem_valid_reg <= mem_valid_reg[mem_raddr];
            p1_byte_reg      <= p1_byte_next;
            p1_notify_reg    <= p1_notify_next;
            p1_ptr_reg       <= p1_ptr_next;
        end
        if (p1_advance && p1_valid_reg) begin
            m_data_reg <= p1_out;
        end
    end

    always_comb begin
        p1_out.read_data      = p1_byte_reg;
        if (p1_use_mem_reg) begin
            p1_out.read_data  = p1_mem_valid_reg ? mem_rdata_reg : 8'd0;
        end
        p1_out.notify         = p1_notify_reg;
        p1_out.notify_pointer = p1_ptr_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/i2ctrf_checker.sv =====
// Port-level checker for the bus target register file, bound to the top level.
`timescale 1ns / 1ps

module i2ctrf_assertions (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input i2ctrf_pkg::in_item_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input i2ctrf_pkg::out_item_t m_data
);
    import i2ctrf_pkg::*;

    // A waiting input transaction must hold still until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("Waiting input transaction changed or dropped.");

    // A stalled result must hold still until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("Stalled result changed or dropped.");

    // The pointer is reported only with a notification.
    a_ptr_with_notify: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.notify) |-> (m_data.notify_pointer == 8'd0))
        else $error("Notification pointer set without notification.");

    // A stop that notifies never returns read data.
    a_notify_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.notify) |-> (m_data.read_data == 8'd0))
        else $error("Read data returned with a notification.");

    // The input side never stalls while the result side can move.
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("Input stalled while the result side was free.");

endmodule

bind i2c_target_register_file_unit i2ctrf_assertions u_i2ctrf_assertions (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/i2ctrf_checker.sv =====
// Checker that predicts and compares every result of the bus target register file.
`timescale 1ns / 1ps

module i2ctrf_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  i2ctrf_pkg::in_item_t  s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  i2ctrf_pkg::out_item_t m_data,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data,
    output int                    pending_count,
    output int                    mismatch_count
);
    import i2ctrf_pkg::*;

    logic [7:0] map_bytes [0:255];
    logic [7:0] bus_ptr;
    logic       ptr_loaded;
    logic [7:0] busy_bits;
    out_item_t  expected_replies [$];

    function automatic out_item_t apply_bus_event(input in_item_t ev);
        out_item_t reply;
        reply = '0;
        case (ev.func)
            FUNC_START_WR: ptr_loaded = 1'b0;
            FUNC_BUS_WR: begin
                if (!ptr_loaded) begin
                    bus_ptr = ev.data;
                    ptr_loaded = 1'b1;
                end else begin
                    map_bytes[bus_ptr] = ev.data;
                    if (bus_ptr <= CTRL_ADDR_LAST_LOW || bus_ptr == CTRL_ADDR_A ||
                        bus_ptr == CTRL_ADDR_B) begin
                        map_bytes[STATUS_ADDR] = map_bytes[STATUS_ADDR] | busy_bits;
                    end else begin
                        bus_ptr = bus_ptr + 8'd1;
                    end
                end
            end
            FUNC_BUS_RD: begin
                reply.read_data = map_bytes[bus_ptr];
                bus_ptr = bus_ptr + 8'd1;
            end
            FUNC_STOP: begin
                if (map_bytes[STATUS_ADDR] != 8'h00) begin
                    reply.notify = 1'b1;
                    reply.notify_pointer = bus_ptr;
                end
            end
            FUNC_LOCAL_WR: map_bytes[ev.local_address] = ev.data;
            FUNC_LOCAL_RD: reply.read_data = map_bytes[ev.local_address];
            default: ;
        endcase
        return reply;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < 256; i++) begin
                map_bytes[i] = 8'h00;
            end
            bus_ptr = 8'h00;
            ptr_loaded = 1'b0;
            busy_bits = BUSY_MASK_RESET;
            expected_replies.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_wr_en) begin
                busy_bits = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result with nothing pending: read_data=%h notify=%b ptr=%h",
                                 $time, m_data.read_data, m_data.notify, m_data.notify_pointer);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    if (m_data.read_data !== want.read_data || m_data.notify !== want.notify ||
                        m_data.notify_pointer !== want.notify_pointer) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: expected read_data=%h notify=%b ptr=%h, got %h %b %h",
                                     $time, want.read_data, want.notify, want.notify_pointer,
                                     m_data.read_data, m_data.notify, m_data.notify_pointer);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_replies.push_back(apply_bus_event(s_data));
            end
        end
        pending_count = expected_replies.size();
    end

endmodule

// ===== sim/i2c_target_register_file_unit_tb.sv =====
// Testbench top that drives the bus target register file and reports the verdict.
`timescale 1ns / 1ps

module i2c_target_register_file_unit_tb;
    import i2ctrf_pkg::*;

    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam int PHASE_ITEMS = 160;
    localparam int CYCLE_LIMIT = 200000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;

    int pending_count;
    int mismatch_count;
    int cycle_count = 0;
    int items_sent = 0;
    int stall_left = 0;
    bit no_idle = 1'b0;

    i2c_target_register_file_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    i2ctrf_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .pending_count  (pending_count),
        .mismatch_count (mismatch_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        int draw;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            draw = no_idle ? 0 : $urandom_range(0, 6);
            m_ready <= (draw == 0);
            stall_left <= draw;
        end else if (!m_ready) begin
            if (stall_left <= 1) begin
                m_ready <= 1'b1;
                stall_left <= 0;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    task automatic send_event(input logic [2:0] fn, input logic [7:0] addr,
                              input logic [7:0] value);
        int gap;
        in_item_t ev;
        ev.func = fn;
        ev.local_address = addr;
        ev.data = value;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 39) == 0) begin
            no_idle = !no_idle;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= ev;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_busy_mask(input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_pointer();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            return 8'($urandom_range(0, 15));
        end else if (pick == 5) begin
            return 8'($urandom_range(248, 255));
        end
        return 8'($urandom);
    endfunction

    task automatic run_random(input int n);
        int target;
        int pick;
        logic [7:0] addr;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 9) != 0) begin
                    send_event(FUNC_START_WR, 8'($urandom), 8'($urandom));
                end
                send_event(FUNC_BUS_WR, 8'($urandom), pick_pointer());
                repeat ($urandom_range(0, 8)) begin
                    send_event(FUNC_BUS_WR, 8'($urandom), 8'($urandom));
                end
                if ($urandom_range(0, 4) != 0) begin
                    send_event(FUNC_STOP, 8'($urandom), 8'($urandom));
                end
            end else if (pick < 80) begin
                send_event(FUNC_START_WR, 8'($urandom), 8'($urandom));
                send_event(FUNC_BUS_WR, 8'($urandom), pick_pointer());
                send_event(FUNC_START_RD, 8'($urandom), 8'($urandom));
                repeat ($urandom_range(1, 8)) begin
                    send_event(FUNC_BUS_RD, 8'($urandom), 8'($urandom));
                end
                send_event(FUNC_STOP, 8'($urandom), 8'($urandom));
            end else if (pick < 92) begin
                addr = ($urandom_range(0, 2) == 0) ? STATUS_ADDR : 8'($urandom);
                if ($urandom_range(0, 1) == 0) begin
                    send_event(FUNC_LOCAL_WR, addr,
                               ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
                end else begin
                    send_event(FUNC_LOCAL_RD, addr, 8'($urandom));
                end
            end else begin
                send_event(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_event(FUNC_BUS_WR,   8'h00, 8'hFE);
        send_event(FUNC_BUS_WR,   8'h00, 8'hA5);
        send_event(FUNC_BUS_WR,   8'h00, 8'h5A);
        send_event(FUNC_BUS_WR,   8'h00, 8'h33);
        send_event(FUNC_STOP,     8'h00, 8'h00);
        send_event(FUNC_BUS_RD,   8'h00, 8'h00);
        send_event(FUNC_BUS_RD,   8'h00, 8'h00);
        send_event(FUNC_START_RD, 8'h00, 8'h00);
        send_event(FUNC_UNUSED,   8'hFF, 8'hFF);
        send_event(FUNC_LOCAL_RD, 8'hFF, 8'h00);
        send_event(FUNC_LOCAL_RD, 8'hFE, 8'h00);
        send_event(FUNC_LOCAL_WR, STATUS_ADDR, 8'h00);
        send_event(FUNC_STOP,     8'h00, 8'h00);
        send_event(FUNC_START_WR, 8'h00, 8'h00);
        send_event(FUNC_BUS_WR,   8'h00, 8'hFF);
        send_event(FUNC_BUS_RD,   8'h00, 8'h00);
        send_event(FUNC_START_WR, 8'h00, 8'h00);
        send_event(FUNC_BUS_WR,   8'h00, CTRL_ADDR_B);
        send_event(FUNC_BUS_WR,   8'h00, 8'h00);
        send_event(FUNC_BUS_WR,   8'h00, 8'hFF);
        send_event(FUNC_STOP,     8'h00, 8'h00);
        send_event(FUNC_LOCAL_WR, 8'hFF, 8'h00);
        send_event(FUNC_LOCAL_WR, 8'h00, 8'hFF);
        send_event(FUNC_LOCAL_RD, 8'h00, 8'h00);
        send_event(FUNC_BUS_RD,   8'hFF, 8'hFF);
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_busy_mask(8'h00);
                1: write_busy_mask(8'hFF);
                3: write_busy_mask(8'h80);
                default: write_busy_mask(8'($urandom));
            endcase
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
